### hw/rtl/vkne_pkg.sv
// Shared types and constants for the velocity keybed note event unit.
// No dependencies; imported by vkne_velocity and velocity_keybed_note_events_unit.
package vkne_pkg;

   // Key matrix and time base
   localparam int KEY_COUNT = 64;
   localparam int KEY_BITS  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int TIME_BITS = 32;

   // Field widths
   localparam int ROW_W    = 4;
   localparam int POS_W    = 2;
   localparam int IDX_W    = ROW_W + POS_W;
   localparam int NOW_W    = 32;
   localparam int STATUS_W = 8;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int SHIFT_W  = 5;
   localparam int OFFSET_W = 8;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 24;
   localparam int CSR_A_W  = 3;
   localparam int CSR_D_W  = 8;

   // Saturated shifted time difference, signed, holds -QSAT..QSAT
   localparam int Q_W  = 10;
   localparam int QSAT = 256;

   // Event status bytes
   localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;

   // Register reset values
   localparam logic [NOTE_W-1:0]   KEY_BASE_RST   = 7'd29;
   localparam logic [SHIFT_W-1:0]  TIME_SHIFT_RST = 5'd11;
   localparam logic [OFFSET_W-1:0] VEL_OFFSET_RST = 8'd132;
   localparam logic [VEL_W-1:0]    VEL_FLOOR_RST  = 7'd32;
   localparam logic [VEL_W-1:0]    VEL_CEIL_RST   = 7'd127;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_KEY_BASE    = 3'd0,
      CSR_TIME_SHIFT  = 3'd1,
      CSR_VEL_OFFSET  = 3'd2,
      CSR_VEL_FLOOR   = 3'd3,
      CSR_VEL_CEILING = 3'd4
   } csr_index_type;

   typedef logic [TIME_BITS-1:0] stamp_type;

   typedef struct packed {
      logic [NOTE_W-1:0]   key_base;
      logic [SHIFT_W-1:0]  time_shift;
      logic [OFFSET_W-1:0] vel_offset;
      logic [VEL_W-1:0]    vel_floor;
      logic [VEL_W-1:0]    vel_ceiling;
   } cfg_type;

endpackage

### hw/rtl/vkne_velocity.sv
// Strike velocity: offset minus twice the scaled contact time, clamped.
// Depends on vkne_pkg.
module vkne_velocity (
   input  vkne_pkg::cfg_type              cfg,
   input  logic signed [vkne_pkg::Q_W-1:0] q_sat,
   input  logic                           use_floor,
   output logic [vkne_pkg::VEL_W-1:0]     velocity
);
   import vkne_pkg::*;

   localparam int V_W = Q_W + 2;

   logic signed [V_W-1:0] v_raw;
   logic signed [V_W-1:0] ceil_s;
   logic signed [V_W-1:0] floor_s;
   logic signed [V_W-1:0] v_hi;

   always_comb begin
      v_raw   = $signed({{(V_W-OFFSET_W){1'b0}}, cfg.vel_offset})
              - ($signed({{(V_W-Q_W){q_sat[Q_W-1]}}, q_sat}) <<< 1);
      ceil_s  = $signed({{(V_W-VEL_W){1'b0}}, cfg.vel_ceiling});
      floor_s = $signed({{(V_W-VEL_W){1'b0}}, cfg.vel_floor});
      // ceiling first, floor last so the floor wins when they cross
      v_hi = (v_raw > ceil_s) ? ceil_s : v_raw;
      if (use_floor || (v_hi < floor_s)) begin
         velocity = cfg.vel_floor;
      end else begin
         velocity = v_hi[VEL_W-1:0];
      end
   end

endmodule

### hw/rtl/velocity_keybed_note_events_unit.sv
// Top level of the velocity keybed note event unit: key state, stamp RAMs, pipeline.
// Depends on vkne_pkg and vkne_velocity.
//
//  channel | dir | handshake        | payload (low bit first)
//  --------+-----+------------------+------------------------------------------------
//  req     | in  | tvalid/tready    | scan_row, row_position, first_closed,
//          |     |                  | second_closed, now_us
//  rsp     | out | tvalid/tready    | status_byte, note_number, velocity
//  csr     | in  | we (no wait)     | addr = register index, wdata = value
//
// One scan transaction per clock sustained unless rsp stalls; a note event leaves
// through the key update, velocity and output register stages after its scan is taken.
// The rate is set by the per-key read-modify-write: flags live in flops, stamps in
// two RAMs read at accept, with one forwarding register covering back-to-back hits.
// Reset clears config to defaults and all per-key flags; stamp RAMs are not cleared.
// A stalled rsp blocks req only once the output register, the velocity stage and the
// key stage are all full.
module velocity_keybed_note_events_unit (
   input  logic                        clock,
   input  logic                        reset,
   // scan_row[3:0], row_position[5:4], first_closed[6], second_closed[7], now_us[39:8]
   input  logic [vkne_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // status_byte[7:0], note_number[14:8], velocity[21:15], zero fill [23:22]
   output logic [vkne_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [vkne_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [vkne_pkg::CSR_D_W-1:0] csr_wdata
);
   import vkne_pkg::*;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_base    <= KEY_BASE_RST;
         cfg_ff.time_shift  <= TIME_SHIFT_RST;
         cfg_ff.vel_offset  <= VEL_OFFSET_RST;
         cfg_ff.vel_floor   <= VEL_FLOOR_RST;
         cfg_ff.vel_ceiling <= VEL_CEIL_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_KEY_BASE:    cfg_ff.key_base    <= csr_wdata[NOTE_W-1:0];
            CSR_TIME_SHIFT:  cfg_ff.time_shift  <= csr_wdata[SHIFT_W-1:0];
            CSR_VEL_OFFSET:  cfg_ff.vel_offset  <= csr_wdata[OFFSET_W-1:0];
            CSR_VEL_FLOOR:   cfg_ff.vel_floor   <= csr_wdata[VEL_W-1:0];
            CSR_VEL_CEILING: cfg_ff.vel_ceiling <= csr_wdata[VEL_W-1:0];
            default: ;   // indexes past the list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Input unpack and stage enables
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]    req_idx;
   logic [KEY_BITS-1:0] req_key;
   logic                req_key_ok;
   logic                req_c1;
   logic                req_c2;
   stamp_type           req_now;
   logic                req_acc;

   logic en_out;
   logic en2;
   logic en1;

   logic rsp_valid_ff;
   logic s2_valid_ff;
   logic s1_valid_ff;

   assign req_idx    = {req_tdata[ROW_W-1:0], req_tdata[IDX_W-1:ROW_W]};
   assign req_key    = KEY_BITS'(req_idx);
   assign req_key_ok = ({2'b00, req_idx} < 8'(KEY_COUNT));
   assign req_c1     = req_tdata[IDX_W];
   assign req_c2     = req_tdata[IDX_W+1];
   assign req_now    = TIME_BITS'(req_tdata[IDX_W+2 +: NOW_W]);

   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en_out;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign req_acc    = req_tvalid && en1;

   // ---------------------------------------------------------------------------
   // Stage 1: key state read-modify-write
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [KEY_BITS-1:0] s1_key;
   logic                s1_c1_ff;
   logic                s1_c2_ff;
   stamp_type           s1_now_ff;
   logic                s1_adv;

   logic [KEY_COUNT-1:0] first_vld_ff;
   logic [KEY_COUNT-1:0] second_vld_ff;
   logic [KEY_COUNT-1:0] down_ff;

   stamp_type first_mem  [KEY_COUNT];
   stamp_type second_mem [KEY_COUNT];
   stamp_type first_rd_ff;
   stamp_type second_rd_ff;

   // forwarding of a stamp written by the transaction just ahead on the same key
   logic      byp_first_ff;
   logic      byp_second_ff;
   stamp_type byp_now_ff;

   logic      fv_old;
   logic      sv_old;
   logic      down_old;
   logic      wr_first;
   logic      wr_second;
   stamp_type first_new;
   stamp_type second_new;
   stamp_type diff;
   stamp_type diff_sh;
   logic signed [Q_W-1:0] q_sat;
   logic      ev_on;
   logic      ev_off;
   logic [NOTE_W-1:0] s1_note;

   localparam stamp_type QSAT_POS = TIME_BITS'(QSAT);
   localparam stamp_type QSAT_NEG = TIME_BITS'(-QSAT);

   assign s1_key = KEY_BITS'(s1_idx_ff);
   assign s1_adv = s1_valid_ff && en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid && req_key_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_idx_ff     <= req_idx;
         s1_c1_ff      <= req_c1;
         s1_c2_ff      <= req_c2;
         s1_now_ff     <= req_now;
         first_rd_ff   <= first_mem[req_key];
         second_rd_ff  <= second_mem[req_key];
         byp_now_ff    <= s1_now_ff;
         byp_first_ff  <= s1_adv && wr_first && (s1_key == req_key);
         byp_second_ff <= s1_adv && wr_second && (s1_key == req_key);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && wr_first) begin
         first_mem[s1_key] <= s1_now_ff;
      end
      if (s1_adv && wr_second) begin
         second_mem[s1_key] <= s1_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_vld_ff  <= '0;
         second_vld_ff <= '0;
         down_ff       <= '0;
      end else if (s1_adv) begin
         first_vld_ff[s1_key]  <= s1_c1_ff;
         second_vld_ff[s1_key] <= s1_c2_ff;
         if (ev_on) begin
            down_ff[s1_key] <= 1'b1;
         end else if (ev_off) begin
            down_ff[s1_key] <= 1'b0;
         end
      end
   end

   always_comb begin
      fv_old    = first_vld_ff[s1_key];
      sv_old    = second_vld_ff[s1_key];
      down_old  = down_ff[s1_key];
      wr_first  = s1_c1_ff && !fv_old;
      wr_second = s1_c2_ff && !sv_old;

      if (wr_first) begin
         first_new = s1_now_ff;
      end else if (byp_first_ff) begin
         first_new = byp_now_ff;
      end else begin
         first_new = first_rd_ff;
      end
      if (wr_second) begin
         second_new = s1_now_ff;
      end else if (byp_second_ff) begin
         second_new = byp_now_ff;
      end else begin
         second_new = second_rd_ff;
      end

      // wrapped difference read as two's complement, floor-shifted, saturated
      diff    = second_new - first_new;
      diff_sh = stamp_type'($signed(diff) >>> cfg_ff.time_shift);
      priority if ($signed(diff_sh) > $signed(QSAT_POS)) begin
         q_sat = Q_W'(QSAT);
      end else if ($signed(diff_sh) < $signed(QSAT_NEG)) begin
         q_sat = -Q_W'(QSAT);
      end else begin
         q_sat = Q_W'(diff_sh);
      end

      ev_off  = !s1_c2_ff && down_old;
      ev_on   = s1_c2_ff && !down_old;
      s1_note = NOTE_W'({1'b0, s1_idx_ff} + cfg_ff.key_base);
   end

   // ---------------------------------------------------------------------------
   // Stage 2: velocity
   // ---------------------------------------------------------------------------
   logic                  s2_on_ff;
   logic [NOTE_W-1:0]     s2_note_ff;
   logic signed [Q_W-1:0] s2_q_ff;
   logic                  s2_floor_ff;
   logic [VEL_W-1:0]      s2_vel;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff && (ev_on || ev_off);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_on_ff    <= ev_on;
         s2_note_ff  <= s1_note;
         s2_q_ff     <= q_sat;
         s2_floor_ff <= !s1_c1_ff;   // first contact open: no first stamp
      end
   end

   vkne_velocity u_velocity (
      .cfg       (cfg_ff),
      .q_sat     (s2_q_ff),
      .use_floor (s2_floor_ff),
      .velocity  (s2_vel)
   );

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [NOTE_W-1:0]   rsp_note_ff;
   logic [VEL_W-1:0]    rsp_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && s2_valid_ff) begin
         rsp_status_ff <= s2_on_ff ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
         rsp_note_ff   <= s2_note_ff;
         rsp_vel_ff    <= s2_on_ff ? s2_vel : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-STATUS_W-NOTE_W-VEL_W){1'b0}},
                        rsp_vel_ff, rsp_note_ff, rsp_status_ff};

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with key stage empty");

   a_on_sets_down: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && ev_on) |=> down_ff[$past(s1_key)])
      else $error("note-on did not mark key down");

   a_off_clears_down: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && ev_off) |=> !down_ff[$past(s1_key)])
      else $error("note-off did not clear key down");

   a_off_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_NOTE_OFF)) |-> (rsp_vel_ff == '0))
      else $error("note-off with nonzero velocity");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_status_ff == STATUS_NOTE_ON) ||
                        (rsp_status_ff == STATUS_NOTE_OFF)))
      else $error("bad status byte on result");

endmodule
